/* rtl/bst_pkg.sv */
package bst_pkg;

  // default sizing of the table
  localparam int DEF_CAPACITY   = 64;
  localparam int DEF_ITEM_WIDTH = 32;

  // fixed field widths of the command and result ports
  localparam int CMD_W       = 2;
  localparam int VALUE_W     = 32;
  localparam int INDEX_W     = 6;
  localparam int COUNT_W     = 7;
  localparam int LIMIT_W     = 7;
  localparam int LIMIT_RESET = 64;

  // command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT   = 2'd0,
    CMD_ERASE    = 2'd1,
    CMD_CONTAINS = 2'd2,
    CMD_GET      = 2'd3
  } cmd_t;

  // broadcast control from the sequencer to every cell
  typedef struct packed {
    logic do_insert;
    logic do_erase;
  } cell_ctrl_t;

endpackage

/* rtl/bounded_set_table.sv */
// Ordered set of distinct values held in a row of cells, one entry per cell.
// A command is taken when start is high and busy is low; busy then stays high
// for one cycle while every cell compares the value in parallel and the row
// shifts or fills in place. The result appears on the following cycle with
// done high for exactly one cycle and must be captured then, as it cannot be
// held back. A new command may be issued in that same cycle; none is taken
// while busy is high. Writes to the capacity limit take effect at once and
// should be made while no command is in flight.
module bounded_set_table #(
  parameter int CAPACITY   = bst_pkg::DEF_CAPACITY,
  parameter int ITEM_WIDTH = bst_pkg::DEF_ITEM_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [bst_pkg::LIMIT_W-1:0]   cfg_wdata,
  input  logic                          start,
  output logic                          busy,
  input  logic [bst_pkg::CMD_W-1:0]     cmd,
  input  logic [bst_pkg::VALUE_W-1:0]   item_value,
  input  logic [bst_pkg::INDEX_W-1:0]   read_index,
  output logic                          done,
  output logic                          ok,
  output logic [bst_pkg::VALUE_W-1:0]   read_value,
  output logic [bst_pkg::COUNT_W-1:0]   entry_count,
  output logic                          is_empty
);
  import bst_pkg::*;

  localparam int STORE_W = (ITEM_WIDTH < VALUE_W) ? ITEM_WIDTH : VALUE_W;
  localparam int CNT_W   = $clog2(CAPACITY + 1);
  localparam int CMP_W   = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
  localparam logic [CMP_W-1:0] CAP_C = CMP_W'(CAPACITY);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

  state_t               state;
  logic [LIMIT_W-1:0]   capacity_limit;
  logic [CNT_W-1:0]     count;
  logic [CNT_W-1:0]     count_next;
  cmd_t                 req_cmd;
  logic [STORE_W-1:0]   req_value;
  logic [INDEX_W-1:0]   req_index;

  cell_ctrl_t           ctrl;
  logic [CAPACITY-1:0]  cell_valid;
  logic [STORE_W-1:0]   cell_value [CAPACITY];
  logic [CAPACITY-1:0]  cell_hit;
  logic [CAPACITY-1:0]  cell_match;
  logic [CAPACITY-1:0]  cell_sel;

  logic                 found;
  logic                 room;
  logic [CMP_W-1:0]     limit;
  logic                 res_ok;
  logic [STORE_W-1:0]   sel_value;
  logic                 accept;

  assign accept = start && !busy;
  assign busy   = (state == ST_EXEC);

  // capacity register
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity_limit <= LIMIT_W'(LIMIT_RESET);
    end else if (cfg_we) begin
      capacity_limit <= cfg_wdata;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: if (accept) state <= ST_EXEC;
        ST_EXEC: state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
    end
  end

  // capture the accepted item
  always_ff @(posedge clk) begin
    if (accept) begin
      req_cmd   <= cmd_t'(cmd);
      req_value <= item_value[STORE_W-1:0];
      req_index <= read_index;
    end
  end

  // row of cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic             prev_v;
    logic             hit_i;
    logic             next_v;
    logic [STORE_W-1:0] next_d;

    if (i == 0) begin : g_first
      assign prev_v = 1'b1;
      assign hit_i  = 1'b0;
    end else begin : g_mid
      assign prev_v = cell_valid[i-1];
      assign hit_i  = cell_hit[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign next_v = 1'b0;
      assign next_d = cell_value[i];
    end else begin : g_inner
      assign next_v = cell_valid[i+1];
      assign next_d = cell_value[i+1];
    end

    bst_cell #(
      .STORE_W (STORE_W),
      .POS     (i)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .key        (req_value),
      .read_index (req_index),
      .prev_valid (prev_v),
      .hit_in     (hit_i),
      .next_valid (next_v),
      .next_value (next_d),
      .valid      (cell_valid[i]),
      .value      (cell_value[i]),
      .hit_out    (cell_hit[i]),
      .match      (cell_match[i]),
      .sel        (cell_sel[i])
    );
  end

  // presence and room checks
  assign found = |cell_match;
  assign limit = (CMP_W'(capacity_limit) > CAP_C) ? CAP_C : CMP_W'(capacity_limit);
  assign room  = CMP_W'(count) < limit;

  // gather the entry picked by get
  always_comb begin
    sel_value = '0;
    for (int k = 0; k < CAPACITY; k++) begin
      sel_value = sel_value | (cell_sel[k] ? cell_value[k] : '0);
    end
  end

  // decode the command into cell control, outcome and new count
  always_comb begin
    ctrl       = '0;
    res_ok     = 1'b0;
    count_next = count;
    if (state == ST_EXEC) begin
      case (req_cmd)
        CMD_INSERT: begin
          if (room && !found) begin
            ctrl.do_insert = 1'b1;
            res_ok         = 1'b1;
            count_next     = count + 1'b1;
          end
        end
        CMD_ERASE: begin
          if (found) begin
            ctrl.do_erase = 1'b1;
            res_ok        = 1'b1;
            count_next    = count - 1'b1;
          end
        end
        CMD_CONTAINS: res_ok = found;
        CMD_GET:      res_ok = |cell_sel;
        default:      res_ok = 1'b0;
      endcase
    end
  end

  // entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == ST_EXEC);
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (state == ST_EXEC) begin
      ok          <= res_ok;
      read_value  <= (req_cmd == CMD_GET) ? VALUE_W'(sel_value) : '0;
      entry_count <= COUNT_W'(count_next);
      is_empty    <= (count_next == '0);
    end
  end

endmodule

/* rtl/bst_cell.sv */
module bst_cell #(
  parameter int STORE_W = 32,
  parameter int POS     = 0
) (
  input  logic                    clk,
  input  logic                    rst,
  input  bst_pkg::cell_ctrl_t     ctrl,
  input  logic [STORE_W-1:0]      key,
  input  logic [bst_pkg::INDEX_W-1:0] read_index,
  input  logic                    prev_valid,
  input  logic                    hit_in,
  input  logic                    next_valid,
  input  logic [STORE_W-1:0]      next_value,
  output logic                    valid,
  output logic [STORE_W-1:0]      value,
  output logic                    hit_out,
  output logic                    match,
  output logic                    sel
);
  import bst_pkg::*;

  localparam logic INDEXABLE = (POS < (1 << INDEX_W));
  localparam logic [INDEX_W-1:0] POS_IDX = INDEX_W'(POS);

  logic shift_in;
  logic take_key;

  // compare against the key and flag a hit here or further left
  assign match   = valid && (value == key);
  assign hit_out = hit_in | match;
  assign sel     = valid && INDEXABLE && (read_index == POS_IDX);

  // erase pulls the right neighbour in from the hit onwards; insert fills the first free cell
  assign shift_in = ctrl.do_erase && hit_out;
  assign take_key = ctrl.do_insert && prev_valid && !valid;

  // occupancy flag
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (shift_in) begin
      valid <= next_valid;
    end else if (take_key) begin
      valid <= 1'b1;
    end
  end

  // stored item
  always_ff @(posedge clk) begin
    if (shift_in) begin
      value <= next_value;
    end else if (take_key) begin
      value <= key;
    end
  end

endmodule

/* bench/tb_bounded_set_table.sv */
module tb_bounded_set_table;
  import bst_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_DEPTH = DEF_CAPACITY;
  localparam int QUIET_LIMIT = 1000;
  localparam int POOL_SIZE   = 96;

  // one result of the table as the ports show it
  typedef struct packed {
    logic               ok;
    logic [VALUE_W-1:0] read_value;
    logic [COUNT_W-1:0] entry_count;
    logic               is_empty;
  } set_result_t;

  // shadow copy of the table; predicts the result of every accepted item
  class set_shadow;
    logic [VALUE_W-1:0] entries [TABLE_DEPTH];
    int unsigned        count;
    logic [LIMIT_W-1:0] limit;
    set_result_t        pending_results [$];
    int                 errors;

    function new();
      count  = 0;
      limit  = LIMIT_W'(LIMIT_RESET);
      errors = 0;
      foreach (entries[k]) entries[k] = '0;
    endfunction

    function void set_limit(logic [LIMIT_W-1:0] v);
      limit = v;
    endfunction

    function int find_value(logic [VALUE_W-1:0] v);
      for (int k = 0; k < count; k++) begin
        if (entries[k] == v) return k;
      end
      return -1;
    endfunction

    // work out the result of an accepted item and queue it
    function void note_command(cmd_t c, logic [VALUE_W-1:0] v, logic [INDEX_W-1:0] idx);
      int unsigned eff_limit;
      int          pos;
      set_result_t r;
      eff_limit = (limit > TABLE_DEPTH) ? TABLE_DEPTH : limit;
      pos = find_value(v);
      r = '0;
      case (c)
        CMD_INSERT: begin
          if (count < eff_limit && pos < 0) begin
            entries[count] = v;
            count++;
            r.ok = 1'b1;
          end
        end
        CMD_ERASE: begin
          if (pos >= 0) begin
            for (int k = pos; k + 1 < count; k++) entries[k] = entries[k+1];
            count--;
            r.ok = 1'b1;
          end
        end
        CMD_CONTAINS: begin
          r.ok = (pos >= 0);
        end
        default: begin
          if (idx < count) begin
            r.read_value = entries[idx];
            r.ok = 1'b1;
          end
        end
      endcase
      r.entry_count = COUNT_W'(count);
      r.is_empty    = (count == 0);
      pending_results.push_back(r);
    endfunction

    function void report(string msg);
      errors++;
      if (errors <= 10) $display("mismatch: %s", msg);
    endfunction

    // compare a result with the oldest expectation, field by field
    function void check_result(logic got_ok, logic [VALUE_W-1:0] got_value,
                               logic [COUNT_W-1:0] got_count, logic got_empty);
      set_result_t want;
      if (pending_results.size() == 0) begin
        report("result with no command outstanding");
        return;
      end
      want = pending_results.pop_front();
      if (got_ok !== want.ok)
        report($sformatf("ok expected %0b got %0b", want.ok, got_ok));
      if (got_value !== want.read_value)
        report($sformatf("read_value expected %08h got %08h", want.read_value, got_value));
      if (got_count !== want.entry_count)
        report($sformatf("entry_count expected %0d got %0d", want.entry_count, got_count));
      if (got_empty !== want.is_empty)
        report($sformatf("is_empty expected %0b got %0b", want.is_empty, got_empty));
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               cfg_we;
  logic [LIMIT_W-1:0] cfg_wdata;
  logic               start;
  logic               busy;
  logic [CMD_W-1:0]   cmd;
  logic [VALUE_W-1:0] item_value;
  logic [INDEX_W-1:0] read_index;
  logic               done;
  logic               ok;
  logic [VALUE_W-1:0] read_value;
  logic [COUNT_W-1:0] entry_count;
  logic               is_empty;

  set_shadow          shadow;
  logic [VALUE_W-1:0] pool [POOL_SIZE];
  int                 quiet;

  bounded_set_table DUT (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .start       (start),
    .busy        (busy),
    .cmd         (cmd),
    .item_value  (item_value),
    .read_index  (read_index),
    .done        (done),
    .ok          (ok),
    .read_value  (read_value),
    .entry_count (entry_count),
    .is_empty    (is_empty)
  );

  // clock
  initial clk = 1'b0;
  always #4 clk = ~clk;

  // monitor: results, register writes, accepted items and the watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (done) shadow.check_result(ok, read_value, entry_count, is_empty);
      if (cfg_we) shadow.set_limit(cfg_wdata);
      if (start && !busy) shadow.note_command(cmd_t'(cmd), item_value, read_index);
      if (done || (start && !busy)) quiet = 0;
      else quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // offer one item after a random gap and wait until it is taken
  task automatic send_command(input cmd_t c, input logic [VALUE_W-1:0] v,
                              input logic [INDEX_W-1:0] idx, input int idle_pct);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start      <= 1'b1;
    cmd        <= c;
    item_value <= v;
    read_index <= idx;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // stop offering and wait for every outstanding result
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (shadow.pending_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_limit(input logic [LIMIT_W-1:0] v);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic logic [VALUE_W-1:0] pick_value();
    if ($urandom_range(0, 9) == 0) return $urandom;
    return pool[$urandom_range(0, POOL_SIZE - 1)];
  endfunction

  // random items under one limit, with values mostly drawn from a small pool
  task automatic run_phase(input logic [LIMIT_W-1:0] lim, input int idle_pct,
                           input int n, input int ins_pct, input int era_pct);
    int                 r;
    cmd_t               c;
    logic [INDEX_W-1:0] idx;
    write_limit(lim);
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < ins_pct) c = CMD_INSERT;
      else if (r < ins_pct + era_pct) c = CMD_ERASE;
      else if (r < ins_pct + era_pct + (100 - ins_pct - era_pct) / 2) c = CMD_CONTAINS;
      else c = CMD_GET;
      if (shadow.count > 0 && $urandom_range(0, 9) < 7)
        idx = INDEX_W'($urandom_range(0, shadow.count - 1));
      else
        idx = INDEX_W'($urandom_range(0, TABLE_DEPTH - 1));
      send_command(c, pick_value(), idx, idle_pct);
    end
  endtask

  initial begin
    shadow = new();
    quiet  = 0;
    foreach (pool[k]) pool[k] = $urandom;
    pool[0]             = '0;
    pool[POOL_SIZE - 1] = '1;
    rst        <= 1'b1;
    cfg_we     <= 1'b0;
    cfg_wdata  <= '0;
    start      <= 1'b0;
    cmd        <= CMD_INSERT;
    item_value <= '0;
    read_index <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty table, extremes of value, duplicates, gap closing
    write_limit(7'd64);
    send_command(CMD_GET,      32'h0,        6'd0,  0);
    send_command(CMD_CONTAINS, 32'h0,        6'd0,  0);
    send_command(CMD_ERASE,    32'h0,        6'd0,  0);
    send_command(CMD_INSERT,   32'h0,        6'd0,  0);
    send_command(CMD_INSERT,   32'hFFFFFFFF, 6'd63, 0);
    send_command(CMD_INSERT,   32'h0,        6'd0,  0);
    send_command(CMD_CONTAINS, 32'hFFFFFFFF, 6'd0,  0);
    send_command(CMD_GET,      32'h0,        6'd1,  0);
    send_command(CMD_GET,      32'hFFFFFFFF, 6'd63, 0);
    send_command(CMD_INSERT,   32'h12345678, 6'd0,  0);
    send_command(CMD_ERASE,    32'h0,        6'd0,  0);
    send_command(CMD_GET,      32'h0,        6'd0,  0);
    send_command(CMD_GET,      32'h0,        6'd1,  0);
    // full table
    write_limit(7'd2);
    send_command(CMD_INSERT,   32'h9,        6'd0,  0);
    // limit lowered under the count
    write_limit(7'd1);
    send_command(CMD_INSERT,   32'h9,        6'd0,  0);
    send_command(CMD_CONTAINS, 32'hFFFFFFFF, 6'd0,  0);
    send_command(CMD_ERASE,    32'hFFFFFFFF, 6'd0,  0);
    write_limit(7'd0);
    send_command(CMD_INSERT,   32'h3,        6'd0,  0);
    send_command(CMD_GET,      32'h0,        6'd0,  0);

    // random phases over limits and sender gaps
    run_phase(7'd127, 0,  160, 60, 10);
    run_phase(7'd64,  64, 140, 25, 25);
    run_phase(7'd10,  23, 120, 25, 25);
    run_phase(7'd64,  0,  140, 55, 15);
    run_phase(7'd0,   64, 60,  40, 20);
    run_phase(7'd1,   23, 80,  40, 30);
    run_phase(7'd3,   0,  80,  40, 30);
    run_phase(7'd64,  23, 140, 35, 35);
    run_phase(7'd127, 64, 100, 50, 20);

    drain();
    repeat (4) @(posedge clk);
    if (shadow.errors == 0 && shadow.pending_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/bst_pkg.sv
rtl/bst_cell.sv
rtl/bounded_set_table.sv
bench/tb_bounded_set_table.sv
